// ===== rtl/wdt2_pkg.sv =====
// Package for the two-stage watchdog: transaction and state types, operation
// and unlock codes, register offsets and bit masks.
// No dependencies; used by wdt2_step and two_stage_pci_watchdog_unit.
`timescale 1ns / 1ps

package wdt2_pkg;

	// Configuration port geometry.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 20;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_RESUME_PRELOAD = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_PRELOAD   = 1'b1;

	// Reset values, given at full 32 bits and cut to the preload width by users.
	localparam logic [31:0] RESUME_RESET_VALUE = 32'(60 << 10);
	localparam logic [31:0] INIT_PRELOAD_VALUE = 32'h000F_FFFF;

	// Unlock codes written to the reload register.
	localparam logic [31:0] UNLOCK_CODE_FIRST  = 32'h0000_0080;
	localparam logic [31:0] UNLOCK_CODE_SECOND = 32'h0000_0086;

	// Config space offsets and access sizes.
	localparam logic [7:0] CFG_MODE_OFS = 8'h60;
	localparam logic [7:0] CFG_LOCK_OFS = 8'h68;
	localparam logic [2:0] CFG_MODE_SIZE = 3'd2;
	localparam logic [2:0] CFG_LOCK_SIZE = 3'd1;

	// Memory window offsets.
	localparam logic [7:0] BAR_T1_OFS     = 8'h00;
	localparam logic [7:0] BAR_T2_OFS     = 8'h04;
	localparam logic [7:0] BAR_GIS_OFS    = 8'h08;
	localparam logic [7:0] BAR_RELOAD_OFS = 8'h0c;

	// Bit masks.
	localparam logic [31:0] INT_TYPE_MASK = 32'h0000_0003;
	localparam logic [31:0] REBOOT_BIT    = 32'(1 << 5);
	localparam logic [31:0] RELOAD_BIT    = 32'(1 << 8);
	localparam logic [31:0] TIMEOUT_BIT   = 32'(1 << 9);

	typedef enum logic [2:0] {
		OP_CFG_READ     = 3'd0,
		OP_CFG_WRITE    = 3'd1,
		OP_BAR_READ     = 3'd2,
		OP_BAR_WRITE    = 3'd3,
		OP_TICK         = 3'd4,
		OP_RESUME_RESET = 3'd5,
		OP_STOP         = 3'd6
	} op_t;

	typedef enum logic [1:0] {
		UNLOCK_IDLE  = 2'd0,
		UNLOCK_ARMED = 2'd1,
		UNLOCK_OPEN  = 2'd2
	} unlock_t;

	typedef struct packed {
		op_t         operation;
		logic [7:0]  offset;
		logic [2:0]  access_size;
		logic [31:0] write_data;
		logic        msi_enabled;
	} item_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        claimed;
		logic        msi_pulse;
		logic        line_irq;
		logic        reset_request;
	} result_t;

	// Control flags of the watchdog.
	typedef struct packed {
		logic    reboot_on;
		logic    irq_on;
		logic    irq_pending;
		logic    line_level;
		logic    lock_bit;
		logic    dog_enabled;
		logic    counting;
		logic    second_stage;
		unlock_t unlock_step;
		logic    timed_out;
	} flags_t;

	localparam flags_t FLAGS_RESET = '{
		reboot_on:    1'b1,
		irq_on:       1'b0,
		irq_pending:  1'b0,
		line_level:   1'b0,
		lock_bit:     1'b0,
		dog_enabled:  1'b0,
		counting:     1'b0,
		second_stage: 1'b0,
		unlock_step:  UNLOCK_IDLE,
		timed_out:    1'b0
	};

endpackage

// ===== rtl/wdt2_step.sv =====
// Next-state and result logic of the watchdog for one transaction.
// Depends on wdt2_pkg; instantiated by two_stage_pci_watchdog_unit.
`timescale 1ns / 1ps

module wdt2_step #(
	parameter int PRELOAD_WIDTH = 20,
	parameter int TICK_SHIFT    = 10
) (
	input  wdt2_pkg::item_t  item,
	input  wdt2_pkg::flags_t flags,
	input  logic [((PRELOAD_WIDTH > TICK_SHIFT) ? (PRELOAD_WIDTH - TICK_SHIFT) : 1)-1:0]
	                         seconds,
	input  logic [PRELOAD_WIDTH-1:0] preload1,
	input  logic [PRELOAD_WIDTH-1:0] preload2,
	input  logic [PRELOAD_WIDTH-1:0] resume_preload,
	output wdt2_pkg::flags_t flags_nxt,
	output logic [((PRELOAD_WIDTH > TICK_SHIFT) ? (PRELOAD_WIDTH - TICK_SHIFT) : 1)-1:0]
	                         seconds_nxt,
	output logic [PRELOAD_WIDTH-1:0] preload1_nxt,
	output logic [PRELOAD_WIDTH-1:0] preload2_nxt,
	output wdt2_pkg::result_t result
);

	localparam int CNT_W = (PRELOAD_WIDTH > TICK_SHIFT) ? (PRELOAD_WIDTH - TICK_SHIFT) : 1;

	logic [PRELOAD_WIDTH-1:0] shifted1;
	logic [PRELOAD_WIDTH-1:0] shifted2;
	logic [CNT_W-1:0]         load1;
	logic [CNT_W-1:0]         load2;
	logic [CNT_W-1:0]         dec;
	logic                     do_start;
	logic                     was_enabled;
	wdt2_pkg::flags_t         f;
	logic [CNT_W-1:0]         sec;

	assign dec = (seconds != '0) ? (seconds - CNT_W'(1)) : seconds;

	always_comb begin
		f            = flags;
		sec          = seconds;
		preload1_nxt = preload1;
		preload2_nxt = preload2;
		do_start     = 1'b0;
		was_enabled  = flags.dog_enabled;
		result       = '0;

		case (item.operation)
			wdt2_pkg::OP_CFG_READ: begin
				if (item.offset == wdt2_pkg::CFG_LOCK_OFS &&
				    item.access_size == wdt2_pkg::CFG_LOCK_SIZE) begin
					result.read_data = {30'd0, flags.dog_enabled, flags.lock_bit};
					result.claimed   = 1'b1;
				end
			end
			wdt2_pkg::OP_CFG_WRITE: begin
				if (item.offset == wdt2_pkg::CFG_MODE_OFS &&
				    item.access_size == wdt2_pkg::CFG_MODE_SIZE) begin
					f.reboot_on    = (item.write_data & wdt2_pkg::REBOOT_BIT) == '0;
					f.irq_on       = (item.write_data & wdt2_pkg::INT_TYPE_MASK) == '0;
					result.claimed = 1'b1;
				end else if (item.offset == wdt2_pkg::CFG_LOCK_OFS &&
				             item.access_size == wdt2_pkg::CFG_LOCK_SIZE) begin
					if (!flags.lock_bit) begin
						f.lock_bit    = item.write_data[0];
						f.dog_enabled = item.write_data[1];
						if (!was_enabled && f.dog_enabled) begin
							f.second_stage = 1'b0;
							do_start       = 1'b1;
						end else if (!f.dog_enabled) begin
							f.counting = 1'b0;
						end
					end
					result.claimed = 1'b1;
				end
			end
			wdt2_pkg::OP_BAR_READ: begin
				if (item.offset == wdt2_pkg::BAR_GIS_OFS) begin
					result.read_data[0] = flags.irq_on && flags.irq_pending;
				end else if (item.offset == wdt2_pkg::BAR_RELOAD_OFS) begin
					result.read_data = (flags.timed_out ? wdt2_pkg::TIMEOUT_BIT : '0) |
					                   (!flags.second_stage ? wdt2_pkg::RELOAD_BIT : '0);
				end
			end
			wdt2_pkg::OP_BAR_WRITE: begin
				if (item.offset == wdt2_pkg::BAR_GIS_OFS) begin
					if (item.write_data[0]) begin
						f.irq_pending = 1'b0;
						if (flags.irq_on && flags.line_level)
							f.line_level = 1'b0;
					end
				end else if (item.offset == wdt2_pkg::BAR_RELOAD_OFS) begin
					if (item.write_data == wdt2_pkg::UNLOCK_CODE_FIRST) begin
						f.unlock_step = wdt2_pkg::UNLOCK_ARMED;
					end else if (item.write_data == wdt2_pkg::UNLOCK_CODE_SECOND &&
					             flags.unlock_step == wdt2_pkg::UNLOCK_ARMED) begin
						f.unlock_step = wdt2_pkg::UNLOCK_OPEN;
					end else if (flags.unlock_step == wdt2_pkg::UNLOCK_OPEN) begin
						if ((item.write_data & wdt2_pkg::RELOAD_BIT) != '0) begin
							f.second_stage = 1'b0;
							do_start       = 1'b1;
						end
						if ((item.write_data & wdt2_pkg::TIMEOUT_BIT) != '0)
							f.timed_out = 1'b0;
						f.unlock_step = wdt2_pkg::UNLOCK_IDLE;
					end
				end else if (flags.unlock_step == wdt2_pkg::UNLOCK_OPEN) begin
					// Any other offset uses up the unlock; only the preloads store.
					if (item.offset == wdt2_pkg::BAR_T1_OFS)
						preload1_nxt = item.write_data[PRELOAD_WIDTH-1:0];
					else if (item.offset == wdt2_pkg::BAR_T2_OFS)
						preload2_nxt = item.write_data[PRELOAD_WIDTH-1:0];
					f.unlock_step = wdt2_pkg::UNLOCK_IDLE;
				end
			end
			wdt2_pkg::OP_TICK: begin
				if (flags.counting) begin
					sec = dec;
					if (dec == '0) begin
						f.counting = 1'b0;
						if (!flags.second_stage) begin
							if (flags.irq_on) begin
								if (item.msi_enabled)
									result.msi_pulse = 1'b1;
								else
									f.line_level = 1'b1;
								f.irq_pending = 1'b1;
							end
							f.second_stage = 1'b1;
							do_start       = 1'b1;
						end else if (flags.reboot_on) begin
							f.second_stage       = 1'b0;
							f.timed_out          = 1'b1;
							result.reset_request = 1'b1;
						end else begin
							f.second_stage = 1'b0;
							do_start       = 1'b1;
						end
					end
				end
			end
			wdt2_pkg::OP_RESUME_RESET: begin
				f.second_stage = 1'b0;
				preload1_nxt   = resume_preload;
				preload2_nxt   = resume_preload;
				f.unlock_step  = wdt2_pkg::UNLOCK_IDLE;
				do_start       = 1'b1;
			end
			wdt2_pkg::OP_STOP: begin
				f.counting = 1'b0;
			end
			default: begin
			end
		endcase

		// Load values come from the preloads as they stand after this transaction,
		// so a resume-reset loads the new preload.
		shifted1 = preload1_nxt >> TICK_SHIFT;
		shifted2 = preload2_nxt >> TICK_SHIFT;
		load1    = shifted1[CNT_W-1:0];
		load2    = shifted2[CNT_W-1:0];

		// Stage start: the counter loads only while the dog is enabled.
		if (do_start && f.dog_enabled) begin
			sec        = f.second_stage ? load2 : load1;
			f.counting = (sec != '0);
		end

		result.line_irq = f.line_level;
		flags_nxt       = f;
		seconds_nxt     = sec;
	end

endmodule

// ===== rtl/two_stage_pci_watchdog_unit.sv =====
// Two-stage watchdog timer: an input transaction is captured in the input register,
// passes through the next-state logic into the result register and is shown on the
// output from there; throughput is one transaction per cycle while out_stall is low.
// The combinational next-state logic between the input register and the state and
// result registers sets that rate; the output register holds a result under stall.
// Reset (arst_n low, asynchronous) clears both valid flags and returns all
// watchdog state, preloads and the resume preload to their reset values at once.
`timescale 1ns / 1ps

module two_stage_pci_watchdog_unit #(
	parameter int PRELOAD_WIDTH = 20,
	parameter int TICK_SHIFT    = 10
) (
	input  logic        clk,
	input  logic        arst_n,

	// Configuration write port.
	input  logic                            cfg_write_enable,
	input  logic [wdt2_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [PRELOAD_WIDTH-1:0]        cfg_write_data,

	// Input transaction channel.
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  operation,
	input  logic [7:0]  offset,
	input  logic [2:0]  access_size,
	input  logic [31:0] write_data,
	input  logic        msi_enabled,

	// Result transaction channel.
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] read_data,
	output logic        claimed,
	output logic        msi_pulse,
	output logic        line_irq,
	output logic        reset_request
);

	// The down counter holds whole seconds, the preload with its low
	// TICK_SHIFT bits dropped. It keeps one bit when nothing is left.
	localparam int CNT_W = (PRELOAD_WIDTH > TICK_SHIFT) ? (PRELOAD_WIDTH - TICK_SHIFT) : 1;

	localparam logic [PRELOAD_WIDTH-1:0] RESUME_RST =
		wdt2_pkg::RESUME_RESET_VALUE[PRELOAD_WIDTH-1:0];
	localparam logic [PRELOAD_WIDTH-1:0] INIT_RST =
		wdt2_pkg::INIT_PRELOAD_VALUE[PRELOAD_WIDTH-1:0];

	// Input register stage.
	logic              valid_s1;
	wdt2_pkg::item_t   item_s1;

	// Result register stage.
	logic              valid_s2;
	wdt2_pkg::result_t result_s2;

	// Watchdog state.
	wdt2_pkg::flags_t         flags_q;
	logic [CNT_W-1:0]         seconds_q;
	logic [PRELOAD_WIDTH-1:0] preload1_q;
	logic [PRELOAD_WIDTH-1:0] preload2_q;
	logic [PRELOAD_WIDTH-1:0] resume_preload_q;

	// Next-state logic outputs.
	wdt2_pkg::flags_t         flags_nxt;
	logic [CNT_W-1:0]         seconds_nxt;
	logic [PRELOAD_WIDTH-1:0] preload1_nxt;
	logic [PRELOAD_WIDTH-1:0] preload2_nxt;
	wdt2_pkg::result_t        result_nxt;

	logic                                   advance;

	// A transaction leaves the input register whenever the result register is
	// empty or is being emptied in the same cycle. That move is also the moment
	// the watchdog state commits, so the next transaction sees the new state.
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.operation   <= wdt2_pkg::op_t'(operation);
			item_s1.offset      <= offset;
			item_s1.access_size <= access_size;
			item_s1.write_data  <= write_data;
			item_s1.msi_enabled <= msi_enabled;
		end
	end

	wdt2_step #(
		.PRELOAD_WIDTH (PRELOAD_WIDTH),
		.TICK_SHIFT    (TICK_SHIFT)
	) u_step (
		.item           (item_s1),
		.flags          (flags_q),
		.seconds        (seconds_q),
		.preload1       (preload1_q),
		.preload2       (preload2_q),
		.resume_preload (resume_preload_q),
		.flags_nxt      (flags_nxt),
		.seconds_nxt    (seconds_nxt),
		.preload1_nxt   (preload1_nxt),
		.preload2_nxt   (preload2_nxt),
		.result         (result_nxt)
	);

	// State commits together with the transaction moving into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q    <= wdt2_pkg::FLAGS_RESET;
			seconds_q  <= '0;
			preload1_q <= INIT_RST;
			preload2_q <= INIT_RST;
		end else if (advance) begin
			flags_q    <= flags_nxt;
			seconds_q  <= seconds_nxt;
			preload1_q <= preload1_nxt;
			preload2_q <= preload2_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_nxt;
		end
	end

	assign out_valid     = valid_s2;
	assign read_data     = result_s2.read_data;
	assign claimed       = result_s2.claimed;
	assign msi_pulse     = result_s2.msi_pulse;
	assign line_irq      = result_s2.line_irq;
	assign reset_request = result_s2.reset_request;

	// Configuration writes at the preload width.
	// The initial preload only matters at block reset, where both stage
	// preloads take its reset value, so a write to it is taken and dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resume_preload_q <= RESUME_RST;
		end else if (cfg_write_enable) begin
			case (cfg_index)
				wdt2_pkg::CFG_RESUME_PRELOAD: resume_preload_q <= cfg_write_data;
				wdt2_pkg::CFG_INIT_PRELOAD:   resume_preload_q <= resume_preload_q;
				default:                      resume_preload_q <= resume_preload_q;
			endcase
		end
	end

	// The counter runs only with a nonzero count and an enabled dog.
	assert property (@(posedge clk) disable iff (!arst_n)
		flags_q.counting |-> (seconds_q != '0) && flags_q.dog_enabled)
		else $error("watchdog counting with zero count or while disabled");

	// A pending reset request goes with the sticky timeout and a stopped counter.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && result_s2.reset_request |->
			flags_q.timed_out && !flags_q.second_stage && !flags_q.counting)
		else $error("reset request without matching timeout state");

	// A message interrupt comes from a stage one expiry.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && result_s2.msi_pulse |-> flags_q.second_stage && flags_q.irq_pending)
		else $error("message interrupt without stage two and pending status");

	// The line level shown is the committed state while the result waits.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> result_s2.line_irq == flags_q.line_level)
		else $error("line level in result differs from committed state");

endmodule
